@@ hdl/zokd_pkg.sv @@
// zokd_pkg: shared types and constants of the 0/1 knapsack dp block
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none
package zokd_pkg;

  localparam int MAX_CAPACITY = 1024;
  localparam int ADDR_W       = $clog2(MAX_CAPACITY + 1);
  localparam int DATA_W       = 32;
  localparam int WEIGHT_W     = 10;
  localparam int BENEFIT_W    = 10;
  localparam int CAP_W        = 11;

  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [DATA_W-1:0]    data_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [BENEFIT_W-1:0] benefit_t;
  typedef logic [CAP_W-1:0]     cap_t;

  localparam addr_t MAX_ADDR = ADDR_W'(MAX_CAPACITY);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage
`default_nettype wire

@@ hdl/zokd_if.sv @@
// zokd channel interfaces: item input, result output and capacity write
// depends on zokd_pkg for the field types
`timescale 1ns / 1ps
`default_nettype none
interface zokd_in_if;
  import zokd_pkg::*;
  logic     valid;
  logic     ready;
  weight_t  item_weight;
  benefit_t item_benefit;
  logic     last_item;
  modport source(output valid, item_weight, item_benefit, last_item, input ready);
  modport sink(input valid, item_weight, item_benefit, last_item, output ready);
endinterface

interface zokd_out_if;
  import zokd_pkg::*;
  logic  valid;
  logic  ready;
  data_t best_benefit;
  modport source(output valid, best_benefit, input ready);
  modport sink(input valid, best_benefit, output ready);
endinterface

interface zokd_cfg_if;
  import zokd_pkg::*;
  logic valid;
  logic ready;
  cap_t capacity;
  modport source(output valid, capacity, input ready);
  modport sink(input valid, capacity, output ready);
endinterface
`default_nettype wire

@@ hdl/zero_one_knapsack_dp.sv @@
// zero_one_knapsack_dp: 0/1 knapsack solver over a one-row dp table in block ram
// depends on zokd_pkg and the channel interfaces in zokd_if.sv
//
// usage:
//   cfg_ch  writes the capacity (values above 1024 act as 1024); write only while idle
//   in_ch   carries one object per transaction: weight, benefit and a last marker
//   out_ch  carries best_benefit, one transaction per problem, after the last object
// each object sweeps the whole table from entry 1024 down to 0, one entry per
// cycle: two reads (best[w], best[w-weight]) and one write-back a cycle later.
// a new object is taken only after the previous object's sweep, its trailing
// write-back and a turn-around; the table ram port rate sets this.
// on the last object the sweep writes zeros behind itself, so the table is clear
// for the next problem with no extra pass. the result is caught when the sweep
// writes the capacity entry. after reset the table is cleared from entry 1024 down
// to 0, and no object is taken while the clear runs. results go through a holding
// register and an output register; while the receiver stalls the next object is
// still taken if the holding register is free, and no object is taken while the
// holding register keeps a waiting result.
`timescale 1ns / 1ps
`default_nettype none
module zero_one_knapsack_dp (
  input  wire logic   clk,
  input  wire logic   rst_n,
  zokd_cfg_if.sink    cfg_ch,
  zokd_in_if.sink     in_ch,
  zokd_out_if.source  out_ch
);
  import zokd_pkg::*;

  state_t   state_r, state_nxt;
  addr_t    addr_r, addr_nxt;
  cap_t     cap_r;
  weight_t  weight_r;
  benefit_t benefit_r;
  logic     last_r;
  logic     in_ready;
  logic     clear_en;
  logic     accept;

  logic     s1_valid_r;
  addr_t    s1_addr_r;
  logic     s1_fit_r;
  data_t    rd_a_r, rd_b_r;
  addr_t    rd_b_addr;

  logic [DATA_W:0] sum;
  data_t    cand;
  data_t    new_val;
  addr_t    eff_cap;
  logic     wr_en;
  addr_t    wr_addr;
  data_t    wr_data;

  logic     hold_valid_r;
  data_t    hold_r;
  logic     out_valid_r;
  data_t    out_data_r;

  data_t    mem [0:MAX_CAPACITY];

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (cfg_ch.valid) begin
      cap_r <= cfg_ch.capacity;
    end
  end

  assign eff_cap = (cap_r > CAP_W'(MAX_CAPACITY)) ? MAX_ADDR : ADDR_W'(cap_r);

  // sequencer
  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= MAX_ADDR;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    in_ready  = 1'b0;
    clear_en  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clear_en = 1'b1;
        if (addr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r - 1'b1;
        end
      end
      ST_IDLE: begin
        // wait for the trailing write-back and a free holding register
        in_ready = !s1_valid_r && !hold_valid_r;
        if (in_ch.valid && in_ready) begin
          state_nxt = ST_RUN;
          addr_nxt  = MAX_ADDR;
        end
      end
      ST_RUN: begin
        if (addr_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r  <= in_ch.item_weight;
      benefit_r <= in_ch.item_benefit;
      last_r    <= in_ch.last_item;
    end
  end

  // read stage
  assign rd_b_addr = addr_r - ADDR_W'(weight_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= addr_r;
    s1_fit_r  <= (ADDR_W'(weight_r) <= addr_r);
  end

  // table ram: two registered reads, one write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[addr_r];
    rd_b_r <= mem[rd_b_addr];
  end

  // update stage; reads run strictly below the entry being written, so no forwarding
  assign sum     = {1'b0, rd_b_r} + (DATA_W + 1)'(benefit_r);
  assign cand    = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
  assign new_val = (s1_fit_r && (cand > rd_a_r)) ? cand : rd_a_r;

  assign wr_en   = clear_en || s1_valid_r;
  assign wr_addr = clear_en ? addr_r : s1_addr_r;
  assign wr_data = (clear_en || last_r) ? '0 : new_val;

  // result holding and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (hold_valid_r && (!out_valid_r || out_ch.ready)) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_valid_r && last_r && (s1_addr_r == eff_cap)) begin
        hold_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid_r && (!out_valid_r || out_ch.ready)) begin
      out_data_r <= hold_r;
    end
    if (s1_valid_r && last_r && (s1_addr_r == eff_cap)) begin
      hold_r <= new_val;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.best_benefit = out_data_r;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for the 0/1 knapsack dp block, a directed part then random problems
// depends on zokd_pkg, the channel interfaces in zokd_if.sv and zero_one_knapsack_dp
`timescale 1ns / 1ps
module tb_top;
  import zokd_pkg::*;

  localparam int RANDOM_ITEMS = 580;
  // one full sweep of the table plus margin
  localparam int SWEEP_SLACK = 1100;

  logic clk = 1'b0;
  logic rst_n;

  zokd_cfg_if cfg_ch ();
  zokd_in_if  in_ch ();
  zokd_out_if out_ch ();

  zero_one_knapsack_dp dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // own copy of the dp row and the capacity register
  data_t best_row [0:MAX_CAPACITY] = '{default: '0};
  cap_t  capacity_now = '0;
  data_t pending_best [$];
  int    mismatch_count = 0;
  int    burst_left = 1;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ERROR %s", $time, msg);
  endtask

  // folds one object into the row; a last object yields the answer and clears the row
  function automatic void fold_object(input weight_t w, input benefit_t b, input logic last);
    logic [DATA_W:0] sum;
    data_t cand;
    int limit;
    for (int idx = MAX_CAPACITY; idx >= 0; idx--) begin
      if (int'(w) <= idx) begin
        sum = (DATA_W+1)'(best_row[idx - int'(w)]) + (DATA_W+1)'(b);
        cand = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
        if (cand > best_row[idx]) best_row[idx] = cand;
      end
    end
    if (last) begin
      limit = (int'(capacity_now) > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity_now);
      pending_best.push_back(best_row[limit]);
      foreach (best_row[i]) best_row[i] = '0;
    end
  endfunction

  task automatic send_object(input weight_t w, input benefit_t b, input logic last);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.item_weight  <= w;
    in_ch.item_benefit <= b;
    in_ch.last_item    <= last;
    do @(posedge clk); while (!in_ch.ready);
    fold_object(w, b, last);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap = $urandom_range(1, 40);
        6, 7, 8:          gap = $urandom_range(1, 1100);
        default:          gap = 0;
      endcase
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // capacity only changes once every result is in and the last sweep has finished
  task automatic set_capacity(input cap_t value);
    in_ch.valid <= 1'b0;
    while (pending_best.size() != 0) @(negedge clk);
    repeat (SWEEP_SLACK) @(negedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.capacity <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    capacity_now = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic cap_t pick_capacity();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return cap_t'(MAX_CAPACITY);
    if (sel == 2) return '1;
    if (sel <= 5) return cap_t'($urandom_range(1, 64));
    return cap_t'($urandom_range(0, 2047));
  endfunction

  task automatic test_single_objects();
    set_capacity(cap_t'(MAX_CAPACITY));
    send_object(10'd1023, 10'd1023, 1'b1);
    send_object(10'd1, 10'd0, 1'b1);
    // weightless objects fit everywhere and stack up
    send_object(10'd0, 10'd1023, 1'b1);
    send_object(10'd0, 10'd5, 1'b0);
    send_object(10'd0, 10'd7, 1'b1);
  endtask

  task automatic test_zero_capacity();
    set_capacity('0);
    send_object(10'd1, 10'd1023, 1'b0);
    send_object(10'd0, 10'd9, 1'b1);
    send_object(10'd1023, 10'd0, 1'b1);
  endtask

  task automatic test_capacity_clamp();
    set_capacity('1);
    send_object(10'd1023, 10'd100, 1'b0);
    send_object(10'd1, 10'd50, 1'b0);
    send_object(10'd1023, 10'd200, 1'b1);
    set_capacity(cap_t'(MAX_CAPACITY + 1));
    send_object(10'd512, 10'd3, 1'b0);
    send_object(10'd512, 10'd4, 1'b1);
  endtask

  task automatic test_mid_problem_capacity();
    set_capacity(cap_t'(10));
    send_object(10'd6, 10'd10, 1'b0);
    send_object(10'd5, 10'd6, 1'b0);
    set_capacity(cap_t'(11));
    send_object(10'd5, 10'd6, 1'b1);
    set_capacity(cap_t'(682));
    send_object(10'd341, 10'd1000, 1'b0);
    send_object(10'd341, 10'd1000, 1'b0);
    send_object(10'd682, 10'd1023, 1'b1);
  endtask

  task automatic test_random_problems();
    int sent;
    int plen;
    weight_t w;
    benefit_t b;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) set_capacity(pick_capacity());
      plen = $urandom_range(1, 8);
      for (int k = 0; k < plen; k++) begin
        if (k > 0 && $urandom_range(0, 19) == 0) set_capacity(pick_capacity());
        case ($urandom_range(0, 9))
          0:             w = '0;
          1:             w = '1;
          2, 3, 4, 5:    w = weight_t'($urandom_range(1, 64));
          6, 7:          w = weight_t'($urandom_range(0, 1023));
          default:       w = weight_t'($urandom_range(100, 600));
        endcase
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = '1;
          default: b = benefit_t'($urandom_range(0, 1023));
        endcase
        send_object(w, b, k == plen - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.capacity    <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.item_weight  <= '0;
    in_ch.item_benefit <= '0;
    in_ch.last_item    <= 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_objects();
    test_zero_capacity();
    test_capacity_clamp();
    test_mid_problem_capacity();
    test_random_problems();

    in_ch.valid <= 1'b0;
    while (pending_best.size() != 0) @(negedge clk);
    repeat (SWEEP_SLACK) @(negedge clk);
    if (mismatch_count == 0 && pending_best.size() == 0) begin
      $display("zero_one_knapsack_dp: match");
    end else begin
      $display("zero_one_knapsack_dp: mismatch");
    end
    $finish;
  end

  // receiver: long free runs, choppy stretches and long stalls that back up results
  initial begin : result_ready_pattern
    int span;
    int kind;
    out_ch.ready <= 1'b0;
    forever begin
      kind = $urandom_range(0, 9);
      if (kind < 6) span = $urandom_range(1, 3000);
      else if (kind < 9) span = $urandom_range(1, 200);
      else span = $urandom_range(1, 4000);
      repeat (span) begin
        @(negedge clk);
        if (kind < 6) out_ch.ready <= 1'b1;
        else if (kind < 9) out_ch.ready <= 1'($urandom_range(0, 1));
        else out_ch.ready <= 1'b0;
      end
    end
  end

  // each result transaction is checked against the oldest expected answer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_best.size() == 0) begin
        report_mismatch($sformatf("unexpected best_benefit %0d", out_ch.best_benefit));
      end else if (out_ch.best_benefit !== pending_best[0]) begin
        report_mismatch($sformatf("best_benefit got %0d, expected %0d",
                                  out_ch.best_benefit, pending_best[0]));
        void'(pending_best.pop_front());
      end else begin
        void'(pending_best.pop_front());
      end
    end
  end

  initial begin
    #200_000_000;
    $display("zero_one_knapsack_dp: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/zokd_pkg.sv
hdl/zokd_if.sv
hdl/zero_one_knapsack_dp.sv
verif/tb_top.sv
